// ===== rtl/huf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// huf_pkg: shared types and constants of the Huffman codec
// Field widths, memory entry layouts and the controller-to-datapath command set.
// ---------------------------------------------------------------------------
package huf_pkg;

    localparam int AlphabetSize = 128;
    localparam int NodeDepth    = 256;
    localparam int HeapDepth    = AlphabetSize + 2;
    localparam int MaxTotal     = 1023;
    localparam int MaxCodeBits  = 16;

    localparam int SymW  = 7;
    localparam int NodeW = 8;
    localparam int HeapW = 8;
    localparam int FreqW = 10;
    localparam int CodeW = 16;
    localparam int LenW  = 5;

    typedef enum logic [1:0] {
        ACT_COUNT  = 2'd0,
        ACT_BUILD  = 2'd1,
        ACT_ENCODE = 2'd2,
        ACT_DECODE = 2'd3
    } action_t;

    typedef struct packed {
        logic [FreqW-1:0] freq;
        logic [NodeW-1:0] node;
    } heap_ent_t;

    typedef struct packed {
        logic             leaf;
        logic [SymW-1:0]  sym;
        logic [NodeW-1:0] left;
        logic [NodeW-1:0] right;
    } node_t;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic [LenW-1:0]  len;
    } code_ent_t;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_CLR,
        OP_LATCH,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_ENC_RD,
        OP_ENC_RES,
        OP_DEC_RD,
        OP_DEC_STEP,
        OP_DEC_LEAF,
        OP_DEC_ERR,
        OP_B_INIT,
        OP_L_RD,
        OP_L_CHK,
        OP_P_START,
        OP_P_TEST,
        OP_P_CMP,
        OP_T_RD1,
        OP_T_TOP,
        OP_T_TEST,
        OP_T_L,
        OP_T_R,
        OP_T_LAST,
        OP_M_NEW,
        OP_R_RD,
        OP_R_GET,
        OP_A_RD,
        OP_A_DO,
        OP_A_DO2,
        OP_A_NEXT,
        OP_B_FAIL,
        OP_B_OK,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel;     // take result goes to second operand
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    sym_zero;
        logic    tree_ready;
        logic    s_end;
        logic    hist_nz;
        logic    distinct_zero;
        logic    hend_gt2;
        logic    has_l;
        logic    has_r;
        logic    put_top;
        logic    put_stop;
        logic    rd_leaf;
        logic    k_zero;
        logic    out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/huf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// huf_if: request and result channels of the Huffman codec
// Valid/ready channels carrying one request or one result each.
// ---------------------------------------------------------------------------
interface huf_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [huf_pkg::SymW-1:0]    symbol;
    logic                        code_bit;

    modport source (output valid, action, symbol, code_bit, input ready);
    modport sink   (input valid, action, symbol, code_bit, output ready);
endinterface

interface huf_out_if;
    logic                        valid;
    logic                        ready;
    logic [huf_pkg::SymW-1:0]    out_symbol;
    logic [huf_pkg::CodeW-1:0]   code_word;
    logic [huf_pkg::LenW-1:0]    code_length;
    logic [huf_pkg::SymW-1:0]    distinct_symbols;
    logic                        error_flag;

    modport source (output valid, out_symbol, code_word, code_length, distinct_symbols,
                    error_flag, input ready);
    modport sink   (input valid, out_symbol, code_word, code_length, distinct_symbols,
                    error_flag, output ready);
endinterface
`default_nettype wire

// ===== rtl/huf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// huf_dp: Huffman codec datapath
// Histogram, node pool, heap and code table memories with their registers.
// ---------------------------------------------------------------------------
module huf_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire huf_pkg::cmd_t               cmd,
    output huf_pkg::status_t                 status,
    input  wire logic [1:0]                  action,
    input  wire logic [huf_pkg::SymW-1:0]    symbol,
    input  wire logic                        code_bit,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [huf_pkg::SymW-1:0]         out_symbol,
    output logic [huf_pkg::CodeW-1:0]        code_word,
    output logic [huf_pkg::LenW-1:0]         code_length,
    output logic [huf_pkg::SymW-1:0]         distinct_symbols,
    output logic                             error_flag
);

    // memories
    logic [huf_pkg::FreqW-1:0] hist_mem  [huf_pkg::AlphabetSize];
    huf_pkg::code_ent_t        code_mem  [huf_pkg::AlphabetSize];
    huf_pkg::node_t            node_mem  [huf_pkg::NodeDepth];
    huf_pkg::code_ent_t        ncode_mem [huf_pkg::NodeDepth];
    huf_pkg::heap_ent_t        heap_mem  [huf_pkg::HeapDepth];

    logic [huf_pkg::FreqW-1:0] hist_rd;
    huf_pkg::code_ent_t        code_rd;
    huf_pkg::node_t            node_rd;
    huf_pkg::code_ent_t        ncode_rd;
    huf_pkg::heap_ent_t        heap_rd;

    logic                      hist_we, hist_re;
    logic [huf_pkg::SymW-1:0]  hist_wa, hist_ra;
    logic [huf_pkg::FreqW-1:0] hist_wd;
    logic                      code_we, code_re;
    logic [huf_pkg::SymW-1:0]  code_wa, code_ra;
    huf_pkg::code_ent_t        code_wd;
    logic                      node_we, node_re;
    logic [huf_pkg::NodeW-1:0] node_wa, node_ra;
    huf_pkg::node_t            node_wd;
    logic                      ncode_we, ncode_re;
    logic [huf_pkg::NodeW-1:0] ncode_wa, ncode_ra;
    huf_pkg::code_ent_t        ncode_wd;
    logic                      heap_we, heap_re;
    logic [huf_pkg::HeapW-1:0] heap_wa, heap_ra;
    huf_pkg::heap_ent_t        heap_wd;

    // control registers
    logic [huf_pkg::FreqW-1:0] total_reg;
    logic [7:0]                s_reg;
    logic [huf_pkg::HeapW-1:0] hend_reg;
    logic [huf_pkg::NodeW-1:0] nc_reg;
    logic [huf_pkg::SymW-1:0]  distinct_reg;
    logic                      tree_ready_reg;
    logic [huf_pkg::NodeW-1:0] root_reg;
    logic [huf_pkg::NodeW-1:0] cursor_reg;
    logic                      out_valid_reg;

    // payload registers
    huf_pkg::action_t          act_reg;
    logic [huf_pkg::SymW-1:0]  sym_reg;
    logic                      bit_reg;
    logic [huf_pkg::NodeW-1:0] child_reg;
    logic [huf_pkg::HeapW-1:0] i_reg;
    logic [huf_pkg::NodeW-1:0] k_reg;
    huf_pkg::heap_ent_t        put_reg, a_reg, b_reg, lq_reg;
    logic [huf_pkg::SymW-1:0]  res_sym_reg;
    logic [huf_pkg::CodeW-1:0] res_cw_reg;
    logic [huf_pkg::LenW-1:0]  res_cl_reg;
    logic                      res_err_reg;
    logic [huf_pkg::SymW-1:0]  out_sym_reg;
    logic [huf_pkg::CodeW-1:0] out_cw_reg;
    logic [huf_pkg::LenW-1:0]  out_cl_reg;
    logic [huf_pkg::SymW-1:0]  out_dist_reg;
    logic                      out_err_reg;

    logic                      sat;
    logic [huf_pkg::HeapW:0]   l_idx, r_idx;
    logic                      pick_r;
    logic [huf_pkg::NodeW-1:0] dec_child;
    logic [huf_pkg::LenW-1:0]  child_depth;
    huf_pkg::code_ent_t        leaf_code;
    logic                      leaf_write;

    assign sat         = (total_reg >= huf_pkg::FreqW'(huf_pkg::MaxTotal));
    assign l_idx       = {i_reg, 1'b0};
    assign r_idx       = l_idx + 9'd1;
    assign pick_r      = (heap_rd.freq < lq_reg.freq);
    assign dec_child   = bit_reg ? node_rd.right : node_rd.left;
    assign child_depth = (ncode_rd.len >= huf_pkg::LenW'(huf_pkg::MaxCodeBits + 1))
                       ? huf_pkg::LenW'(huf_pkg::MaxCodeBits + 1) : ncode_rd.len + 5'd1;

    // lone-symbol root gets code 0 of length 1; over-long codes stay cleared
    always_comb
    begin
        leaf_code  = '{code: ncode_rd.code, len: ncode_rd.len};
        leaf_write = (ncode_rd.len <= huf_pkg::LenW'(huf_pkg::MaxCodeBits));
        if (k_reg == root_reg)
        begin
            leaf_code  = '{code: '0, len: huf_pkg::LenW'(1)};
            leaf_write = 1'b1;
        end
    end

    always_comb
    begin
        hist_we  = 1'b0; hist_re  = 1'b0; hist_wa  = sym_reg;  hist_ra = sym_reg;
        hist_wd  = '0;
        code_we  = 1'b0; code_re  = 1'b0; code_wa  = sym_reg;  code_ra = sym_reg;
        code_wd  = '0;
        node_we  = 1'b0; node_re  = 1'b0; node_wa  = nc_reg;   node_ra = cursor_reg;
        node_wd  = '0;
        ncode_we = 1'b0; ncode_re = 1'b0; ncode_wa = root_reg; ncode_ra = k_reg;
        ncode_wd = '0;
        heap_we  = 1'b0; heap_re  = 1'b0; heap_wa  = i_reg;    heap_ra = i_reg;
        heap_wd  = put_reg;
        case (cmd.op)
            huf_pkg::OP_CLR:
            begin
                hist_we = 1'b1;
                hist_wa = s_reg[huf_pkg::SymW-1:0];
            end
            huf_pkg::OP_CNT_RD:  hist_re = 1'b1;
            huf_pkg::OP_CNT_WR:
            begin
                hist_we = !sat;
                hist_wd = hist_rd + 10'd1;
            end
            huf_pkg::OP_ENC_RD:  code_re = 1'b1;
            huf_pkg::OP_DEC_RD:  node_re = 1'b1;
            huf_pkg::OP_DEC_STEP:
            begin
                node_re = 1'b1;
                node_ra = dec_child;
            end
            huf_pkg::OP_L_RD:
            begin
                hist_re = 1'b1;
                hist_ra = s_reg[huf_pkg::SymW-1:0];
                code_we = 1'b1;
                code_wa = s_reg[huf_pkg::SymW-1:0];
            end
            huf_pkg::OP_L_CHK:
            begin
                hist_we = 1'b1;
                hist_wa = s_reg[huf_pkg::SymW-1:0];
                node_we = (hist_rd != '0);
                node_wd = '{leaf: 1'b1, sym: s_reg[huf_pkg::SymW-1:0], left: '0, right: '0};
            end
            huf_pkg::OP_P_TEST:
            begin
                heap_re = 1'b1;
                heap_ra = {1'b0, i_reg[huf_pkg::HeapW-1:1]};
                heap_we = (i_reg[huf_pkg::HeapW-1:1] == '0);
            end
            huf_pkg::OP_P_CMP:
            begin
                heap_we = 1'b1;
                heap_wd = (heap_rd.freq <= put_reg.freq) ? put_reg : heap_rd;
            end
            huf_pkg::OP_T_RD1, huf_pkg::OP_R_RD:
            begin
                heap_re = 1'b1;
                heap_ra = huf_pkg::HeapW'(1);
            end
            huf_pkg::OP_T_TEST:
            begin
                heap_re = 1'b1;
                heap_ra = status.has_l ? l_idx[huf_pkg::HeapW-1:0] : hend_reg;
            end
            huf_pkg::OP_T_L:
            begin
                heap_re = status.has_r;
                heap_ra = r_idx[huf_pkg::HeapW-1:0];
                heap_we = !status.has_r;
                heap_wd = heap_rd;
            end
            huf_pkg::OP_T_R:
            begin
                heap_we = 1'b1;
                heap_wd = pick_r ? heap_rd : lq_reg;
            end
            huf_pkg::OP_T_LAST:
            begin
                heap_we = 1'b1;
                heap_wd = heap_rd;
            end
            huf_pkg::OP_M_NEW:
            begin
                node_we = 1'b1;
                node_wd = '{leaf: 1'b0, sym: '0, left: a_reg.node, right: b_reg.node};
            end
            huf_pkg::OP_R_GET:
            begin
                ncode_we = 1'b1;
                ncode_wa = heap_rd.node;
            end
            huf_pkg::OP_A_RD:
            begin
                node_re  = 1'b1;
                node_ra  = k_reg;
                ncode_re = 1'b1;
            end
            huf_pkg::OP_A_DO:
            begin
                code_we  = node_rd.leaf && leaf_write;
                code_wa  = node_rd.sym;
                code_wd  = leaf_code;
                ncode_we = !node_rd.leaf;
                ncode_wa = node_rd.left;
                ncode_wd = '{code: {ncode_rd.code[huf_pkg::CodeW-2:0], 1'b0}, len: child_depth};
            end
            huf_pkg::OP_A_DO2:
            begin
                ncode_we = 1'b1;
                ncode_wa = node_rd.right;
                ncode_wd = '{code: {ncode_rd.code[huf_pkg::CodeW-2:0], 1'b1}, len: child_depth};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (hist_re)
        begin
            hist_rd <= hist_mem[hist_ra];
        end
        if (code_we)
        begin
            code_mem[code_wa] <= code_wd;
        end
        if (code_re)
        begin
            code_rd <= code_mem[code_ra];
        end
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        if (node_re)
        begin
            node_rd <= node_mem[node_ra];
        end
        if (ncode_we)
        begin
            ncode_mem[ncode_wa] <= ncode_wd;
        end
        if (ncode_re)
        begin
            ncode_rd <= ncode_mem[ncode_ra];
        end
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (heap_re)
        begin
            heap_rd <= heap_mem[heap_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            s_reg          <= '0;
            hend_reg       <= huf_pkg::HeapW'(1);
            nc_reg         <= '0;
            distinct_reg   <= '0;
            tree_ready_reg <= 1'b0;
            root_reg       <= '0;
            cursor_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == huf_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                huf_pkg::OP_CLR:      s_reg <= s_reg + 8'd1;
                huf_pkg::OP_CNT_WR:
                begin
                    if (!sat)
                    begin
                        total_reg <= total_reg + 10'd1;
                    end
                end
                huf_pkg::OP_DEC_STEP:
                begin
                    if (node_rd.leaf)
                    begin
                        cursor_reg <= root_reg;
                    end
                end
                huf_pkg::OP_DEC_LEAF: cursor_reg <= node_rd.leaf ? root_reg : child_reg;
                huf_pkg::OP_B_INIT:
                begin
                    hend_reg       <= huf_pkg::HeapW'(1);
                    nc_reg         <= '0;
                    distinct_reg   <= '0;
                    tree_ready_reg <= 1'b0;
                    s_reg          <= 8'd1;
                end
                huf_pkg::OP_L_CHK:
                begin
                    s_reg <= s_reg + 8'd1;
                    if (hist_rd != '0)
                    begin
                        nc_reg       <= nc_reg + 8'd1;
                        distinct_reg <= distinct_reg + 7'd1;
                    end
                end
                huf_pkg::OP_P_START:  hend_reg <= hend_reg + 8'd1;
                huf_pkg::OP_T_TOP:    hend_reg <= hend_reg - 8'd1;
                huf_pkg::OP_M_NEW:    nc_reg   <= nc_reg + 8'd1;
                huf_pkg::OP_R_GET:    root_reg <= heap_rd.node;
                huf_pkg::OP_B_FAIL:
                begin
                    tree_ready_reg <= 1'b0;
                    root_reg       <= '0;
                    cursor_reg     <= '0;
                    total_reg      <= '0;
                end
                huf_pkg::OP_B_OK:
                begin
                    tree_ready_reg <= 1'b1;
                    cursor_reg     <= root_reg;
                    total_reg      <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            huf_pkg::OP_LATCH:
            begin
                act_reg <= huf_pkg::action_t'(action);
                sym_reg <= symbol;
                bit_reg <= code_bit;
            end
            huf_pkg::OP_CNT_WR:
            begin
                res_sym_reg <= sym_reg;
                res_cw_reg  <= '0;
                res_cl_reg  <= '0;
                res_err_reg <= sat;
            end
            huf_pkg::OP_ENC_RES:
            begin
                res_sym_reg <= sym_reg;
                res_cw_reg  <= tree_ready_reg ? code_rd.code : '0;
                res_cl_reg  <= tree_ready_reg ? code_rd.len : '0;
                res_err_reg <= !tree_ready_reg || (code_rd.len == '0);
            end
            huf_pkg::OP_DEC_STEP:
            begin
                child_reg   <= dec_child;
                res_sym_reg <= bit_reg ? '0 : node_rd.sym;
                res_cw_reg  <= '0;
                res_cl_reg  <= '0;
                res_err_reg <= bit_reg;
            end
            huf_pkg::OP_DEC_LEAF:
            begin
                res_sym_reg <= node_rd.sym;
                res_cw_reg  <= '0;
                res_cl_reg  <= '0;
                res_err_reg <= 1'b0;
            end
            huf_pkg::OP_DEC_ERR, huf_pkg::OP_B_FAIL, huf_pkg::OP_B_OK:
            begin
                res_sym_reg <= '0;
                res_cw_reg  <= '0;
                res_cl_reg  <= '0;
                res_err_reg <= (cmd.op != huf_pkg::OP_B_OK);
            end
            huf_pkg::OP_L_CHK:   put_reg <= '{freq: hist_rd, node: nc_reg};
            huf_pkg::OP_P_START: i_reg <= hend_reg;
            huf_pkg::OP_P_CMP:
            begin
                if (heap_rd.freq > put_reg.freq)
                begin
                    i_reg <= {1'b0, i_reg[huf_pkg::HeapW-1:1]};
                end
            end
            huf_pkg::OP_T_TOP:
            begin
                if (cmd.sel)
                begin
                    b_reg <= heap_rd;
                end
                else
                begin
                    a_reg <= heap_rd;
                end
                i_reg <= huf_pkg::HeapW'(1);
            end
            huf_pkg::OP_T_L:
            begin
                lq_reg <= heap_rd;
                if (!status.has_r)
                begin
                    i_reg <= l_idx[huf_pkg::HeapW-1:0];
                end
            end
            huf_pkg::OP_T_R:
                i_reg <= pick_r ? r_idx[huf_pkg::HeapW-1:0] : l_idx[huf_pkg::HeapW-1:0];
            huf_pkg::OP_M_NEW:   put_reg <= '{freq: a_reg.freq + b_reg.freq, node: nc_reg};
            huf_pkg::OP_R_GET:   k_reg <= nc_reg - 8'd1;
            huf_pkg::OP_A_NEXT:  k_reg <= k_reg - 8'd1;
            huf_pkg::OP_EMIT:
            begin
                out_sym_reg  <= res_sym_reg;
                out_cw_reg   <= res_cw_reg;
                out_cl_reg   <= res_cl_reg;
                out_dist_reg <= distinct_reg;
                out_err_reg  <= res_err_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        status.act           = act_reg;
        status.sym_zero      = (sym_reg == '0);
        status.tree_ready    = tree_ready_reg;
        status.s_end         = (s_reg == 8'(huf_pkg::AlphabetSize));
        status.hist_nz       = (hist_rd != '0);
        status.distinct_zero = (distinct_reg == '0);
        status.hend_gt2      = (hend_reg > huf_pkg::HeapW'(2));
        status.has_l         = (l_idx < {1'b0, hend_reg});
        status.has_r         = (r_idx < {1'b0, hend_reg});
        status.put_top       = (i_reg[huf_pkg::HeapW-1:1] == '0);
        status.put_stop      = (heap_rd.freq <= put_reg.freq);
        status.rd_leaf       = node_rd.leaf;
        status.k_zero        = (k_reg == '0);
        status.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign out_symbol       = out_sym_reg;
    assign code_word        = out_cw_reg;
    assign code_length      = out_cl_reg;
    assign distinct_symbols = out_dist_reg;
    assign error_flag       = out_err_reg;

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hend_reg <= huf_pkg::HeapW'(huf_pkg::HeapDepth - 1))
        else $error("heap end past heap depth");

    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == huf_pkg::OP_T_TOP |-> hend_reg >= huf_pkg::HeapW'(2))
        else $error("take from empty heap");

    a_ready_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        tree_ready_reg |-> distinct_reg != '0)
        else $error("tree ready with no symbols");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == huf_pkg::OP_EMIT |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

// ===== rtl/huf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// huf_ctrl: Huffman codec controller
// Sequences count, encode, decode and the multi-cycle tree build.
// ---------------------------------------------------------------------------
module huf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire huf_pkg::status_t  status,
    output huf_pkg::cmd_t          cmd
);

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_DISPATCH,
        S_CNT_RD, S_CNT_WR, S_ENC_RD, S_ENC_RES,
        S_DEC_RD, S_DEC_STEP, S_DEC_LEAF, S_DEC_ERR,
        S_B_INIT, S_L_RD, S_L_CHK, S_L_NEXT, S_L_END,
        S_P_START, S_P_TEST, S_P_CMP,
        S_M_CHECK, S_T_RD1, S_T_TOP, S_T_TEST, S_T_L, S_T_R, S_T_LAST, S_M_NEW,
        S_R_RD, S_R_GET, S_A_RD, S_A_DO, S_A_DO2, S_A_NEXT,
        S_B_FAIL, S_B_OK, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   leaf_phase_reg, leaf_phase_next;
    logic   take_b_reg, take_b_next;
    state_t put_ret;

    assign put_ret = leaf_phase_reg ? S_L_NEXT : S_M_CHECK;

    always_comb
    begin
        state_next      = state_reg;
        leaf_phase_next = leaf_phase_reg;
        take_b_next     = take_b_reg;
        cmd.op          = huf_pkg::OP_NONE;
        cmd.sel         = take_b_reg;
        case (state_reg)
            S_CLR:
            begin
                if (status.s_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = huf_pkg::OP_CLR;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = huf_pkg::OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.act)
                    huf_pkg::ACT_COUNT:  state_next = status.sym_zero ? S_IDLE : S_CNT_RD;
                    huf_pkg::ACT_BUILD:  state_next = S_B_INIT;
                    huf_pkg::ACT_ENCODE: state_next = status.sym_zero ? S_IDLE : S_ENC_RD;
                    default:             state_next = status.tree_ready ? S_DEC_RD : S_DEC_ERR;
                endcase
            end
            S_CNT_RD:
            begin
                cmd.op     = huf_pkg::OP_CNT_RD;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                cmd.op     = huf_pkg::OP_CNT_WR;
                state_next = S_EMIT;
            end
            S_ENC_RD:
            begin
                cmd.op     = huf_pkg::OP_ENC_RD;
                state_next = S_ENC_RES;
            end
            S_ENC_RES:
            begin
                cmd.op     = huf_pkg::OP_ENC_RES;
                state_next = S_EMIT;
            end
            S_DEC_RD:
            begin
                cmd.op     = huf_pkg::OP_DEC_RD;
                state_next = S_DEC_STEP;
            end
            S_DEC_STEP:
            begin
                cmd.op     = huf_pkg::OP_DEC_STEP;
                state_next = status.rd_leaf ? S_EMIT : S_DEC_LEAF;
            end
            S_DEC_LEAF:
            begin
                cmd.op     = huf_pkg::OP_DEC_LEAF;
                state_next = status.rd_leaf ? S_EMIT : S_IDLE;
            end
            S_DEC_ERR:
            begin
                cmd.op     = huf_pkg::OP_DEC_ERR;
                state_next = S_EMIT;
            end
            S_B_INIT:
            begin
                cmd.op          = huf_pkg::OP_B_INIT;
                leaf_phase_next = 1'b1;
                state_next      = S_L_RD;
            end
            S_L_RD:
            begin
                cmd.op     = huf_pkg::OP_L_RD;
                state_next = S_L_CHK;
            end
            S_L_CHK:
            begin
                cmd.op     = huf_pkg::OP_L_CHK;
                state_next = status.hist_nz ? S_P_START : S_L_NEXT;
            end
            S_L_NEXT:   state_next = status.s_end ? S_L_END : S_L_RD;
            S_L_END:
            begin
                leaf_phase_next = 1'b0;
                take_b_next     = 1'b0;
                state_next      = status.distinct_zero ? S_B_FAIL : S_M_CHECK;
            end
            S_P_START:
            begin
                cmd.op     = huf_pkg::OP_P_START;
                state_next = S_P_TEST;
            end
            S_P_TEST:
            begin
                cmd.op     = huf_pkg::OP_P_TEST;
                state_next = status.put_top ? put_ret : S_P_CMP;
            end
            S_P_CMP:
            begin
                cmd.op     = huf_pkg::OP_P_CMP;
                state_next = status.put_stop ? put_ret : S_P_TEST;
            end
            S_M_CHECK:  state_next = status.hend_gt2 ? S_T_RD1 : S_R_RD;
            S_T_RD1:
            begin
                cmd.op     = huf_pkg::OP_T_RD1;
                state_next = S_T_TOP;
            end
            S_T_TOP:
            begin
                cmd.op     = huf_pkg::OP_T_TOP;
                state_next = S_T_TEST;
            end
            S_T_TEST:
            begin
                cmd.op     = huf_pkg::OP_T_TEST;
                state_next = status.has_l ? S_T_L : S_T_LAST;
            end
            S_T_L:
            begin
                cmd.op     = huf_pkg::OP_T_L;
                state_next = status.has_r ? S_T_R : S_T_TEST;
            end
            S_T_R:
            begin
                cmd.op     = huf_pkg::OP_T_R;
                state_next = S_T_TEST;
            end
            S_T_LAST:
            begin
                cmd.op      = huf_pkg::OP_T_LAST;
                take_b_next = !take_b_reg;
                state_next  = take_b_reg ? S_M_NEW : S_T_RD1;
            end
            S_M_NEW:
            begin
                cmd.op     = huf_pkg::OP_M_NEW;
                state_next = S_P_START;
            end
            S_R_RD:
            begin
                cmd.op     = huf_pkg::OP_R_RD;
                state_next = S_R_GET;
            end
            S_R_GET:
            begin
                cmd.op     = huf_pkg::OP_R_GET;
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                cmd.op     = huf_pkg::OP_A_RD;
                state_next = S_A_DO;
            end
            S_A_DO:
            begin
                cmd.op     = huf_pkg::OP_A_DO;
                state_next = status.rd_leaf ? S_A_NEXT : S_A_DO2;
            end
            S_A_DO2:
            begin
                cmd.op     = huf_pkg::OP_A_DO2;
                state_next = S_A_NEXT;
            end
            S_A_NEXT:
            begin
                if (status.k_zero)
                begin
                    state_next = S_B_OK;
                end
                else
                begin
                    cmd.op     = huf_pkg::OP_A_NEXT;
                    state_next = S_A_RD;
                end
            end
            S_B_FAIL:
            begin
                cmd.op     = huf_pkg::OP_B_FAIL;
                state_next = S_EMIT;
            end
            S_B_OK:
            begin
                cmd.op     = huf_pkg::OP_B_OK;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = huf_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            leaf_phase_reg <= 1'b0;
            take_b_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            leaf_phase_reg <= leaf_phase_next;
            take_b_reg     <= take_b_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/huffman_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// huffman_codec: Huffman histogram, tree build, encoder and decoder
// Controller and datapath joined by command and status structs.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                          
//  req_ch    in   action, symbol, code_bit                        
//  res_ch    out  out_symbol, code_word, code_length,             
//                 distinct_symbols, error_flag                    
//
//  Count and encode run latch, dispatch, one memory read, result and emit from
//  accept to ready again. A zero symbol for count or encode ends after dispatch
//  with no result. Build walks all 127 symbols, inserting each used one into
//  the heap, then runs log-depth sift loops per merge. After reset a pass over
//  all 128 entries zeroes the histogram; no request is taken.
//  A request is taken while a prior result waits; the result waits on ready.
module huffman_codec (
    input  wire logic clk,
    input  wire logic rst_n,
    huf_in_if.sink    req_ch,
    huf_out_if.source res_ch
);

    huf_pkg::cmd_t    cmd;
    huf_pkg::status_t status;

    huf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_ch.valid),
        .in_ready (req_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    huf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .action           (req_ch.action),
        .symbol           (req_ch.symbol),
        .code_bit         (req_ch.code_bit),
        .out_valid        (res_ch.valid),
        .out_ready        (res_ch.ready),
        .out_symbol       (res_ch.out_symbol),
        .code_word        (res_ch.code_word),
        .code_length      (res_ch.code_length),
        .distinct_symbols (res_ch.distinct_symbols),
        .error_flag       (res_ch.error_flag)
    );

endmodule
`default_nettype wire
